[rtl/shhf_pkg.sv]
package shhf_pkg;

  localparam int TICKS_PER_SECOND_DEF = 1000;

  localparam int LIFE_W  = 26;
  localparam int TMR_W   = 16;
  localparam int SECS_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // configuration reset values
  localparam logic [7:0]  HIT_DUTY_RST     = 8'd255;
  localparam logic [7:0]  HOLD_DUTY_RST    = 8'd120;
  localparam logic [15:0] HIT_MS_RST       = 16'd1000;
  localparam logic [9:0]  FADE_STEP_MS_RST = 10'd20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_DUTY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DUTY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_MS       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP_MS = 2'd3;

  // item modes
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_OFF  = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIT  = 2'd1,
    PH_HOLD = 2'd2,
    PH_FADE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SECS_W-1:0] life_seconds;
  } in_t;

  typedef struct packed {
    logic [7:0] duty;
    logic [1:0] phase;
    logic       life_running;
  } out_t;

  typedef struct packed {
    logic [7:0]  hit_duty;
    logic [7:0]  hold_duty;
    logic [15:0] hit_ms;
    logic [9:0]  fade_step_ms;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [7:0]        duty;
    logic [TMR_W-1:0]  tmr;
    logic [LIFE_W-1:0] life;
    logic              lact;
    logic              pv;
    logic              pon;
    logic [SECS_W-1:0] psec;
  } state_t;

endpackage

[rtl/shhf_step.sv]
module shhf_step #(
  parameter int TICKS_PER_SECOND = shhf_pkg::TICKS_PER_SECOND_DEF
) (
  input  shhf_pkg::cfg_t   cfg,
  input  shhf_pkg::state_t st,
  input  shhf_pkg::in_t    item,
  output shhf_pkg::state_t st_nxt
);

  localparam logic [shhf_pkg::LIFE_W-1:0] TPS_L = shhf_pkg::LIFE_W'(TICKS_PER_SECOND);

  logic [shhf_pkg::SECS_W-1:0] secs_sel;
  logic [shhf_pkg::LIFE_W-1:0] life_load;
  logic [shhf_pkg::TMR_W-1:0]  fade_len;

  // one lifetime load per item at most: pending seconds on a tick, else the item's
  assign secs_sel  = (item.mode == shhf_pkg::MODE_TICK) ? st.psec : item.life_seconds;
  assign life_load = shhf_pkg::LIFE_W'(shhf_pkg::LIFE_W'(secs_sel) * TPS_L);
  assign fade_len  = (cfg.fade_step_ms == '0) ? shhf_pkg::TMR_W'(1)
                                              : shhf_pkg::TMR_W'(cfg.fade_step_ms);

  function automatic shhf_pkg::state_t take_cmd(input shhf_pkg::state_t s_in,
                                                input logic on);
    shhf_pkg::state_t s;
    s = s_in;
    if (on) begin
      s.life = life_load;
      s.lact = 1'b1;
      if (cfg.hit_ms == '0) begin
        s.phase = shhf_pkg::PH_HOLD;
        s.duty  = cfg.hold_duty;
      end else begin
        s.phase = shhf_pkg::PH_HIT;
        s.duty  = cfg.hit_duty;
        s.tmr   = cfg.hit_ms;
      end
    end else begin
      s.lact  = 1'b0;
      s.phase = shhf_pkg::PH_FADE;
      s.tmr   = fade_len;
    end
    return s;
  endfunction

  function automatic shhf_pkg::state_t post_cmd(input shhf_pkg::state_t s_in,
                                                input logic on,
                                                input logic [shhf_pkg::SECS_W-1:0] secs);
    shhf_pkg::state_t s;
    s = s_in;
    if (s.phase == shhf_pkg::PH_HIT || s.phase == shhf_pkg::PH_FADE) begin
      s.pv   = 1'b1;
      s.pon  = on;
      s.psec = secs;
    end else begin
      s = take_cmd(s, on);
    end
    return s;
  endfunction

  function automatic shhf_pkg::state_t take_pending(input shhf_pkg::state_t s_in);
    shhf_pkg::state_t s;
    s = s_in;
    if (s.pv) begin
      s.pv = 1'b0;
      s = take_cmd(s, s_in.pon);
    end
    return s;
  endfunction

  always_comb begin
    shhf_pkg::state_t s;
    logic skip;
    s    = st;
    skip = 1'b0;
    unique case (item.mode)
      shhf_pkg::MODE_TICK: begin
        // lifetime first; an expiry that starts a fade ends the tick
        if (s.lact) begin
          if (s.life != '0) s.life = s.life - 1'b1;
          if (s.life == '0) begin
            s.lact = 1'b0;
            skip   = (s.phase == shhf_pkg::PH_IDLE) || (s.phase == shhf_pkg::PH_HOLD);
            s      = post_cmd(s, 1'b0, '0);
          end
        end
        if (!skip) begin
          if (s.phase == shhf_pkg::PH_HIT) begin
            if (s.tmr != '0) s.tmr = s.tmr - 1'b1;
            if (s.tmr == '0) begin
              s.phase = shhf_pkg::PH_HOLD;
              s.duty  = cfg.hold_duty;
              s       = take_pending(s);
            end
          end else if (s.phase == shhf_pkg::PH_FADE) begin
            if (s.tmr != '0) s.tmr = s.tmr - 1'b1;
            if (s.tmr == '0) begin
              if (s.duty != '0) begin
                s.duty = s.duty - 1'b1;
                s.tmr  = fade_len;
              end else begin
                s.phase = shhf_pkg::PH_IDLE;
                s       = take_pending(s);
              end
            end
          end
        end
      end
      shhf_pkg::MODE_ON:  s = post_cmd(s, 1'b1, item.life_seconds);
      shhf_pkg::MODE_OFF: s = post_cmd(s, 1'b0, '0);
      default: ;  // unused mode: state unchanged
    endcase
    st_nxt = s;
  end

endmodule

[rtl/solenoid_hit_hold_fade_driver_core.sv]
// Solenoid hit/hold/fade driver core.
// Input channel (in_valid/in_stall/in_data): each transfer is either a 1 ms tick
// or an on/off command; an on command carries the lifetime in seconds.
// Result channel (out_valid/out_stall/out_data): exactly one result per input
// transfer, showing duty, phase and lifetime status after that item.
// Configuration port (cfg_we/cfg_index/cfg_wdata): plain write, no wait; write
// only while the block is idle.
// Results are registered. Throughput: one item per cycle while in_stall is low;
// the whole update is one combinational pass between the state registers, with
// the lifetime load multiply as the longest path. Output register plus one skid
// entry: while the receiver stalls, one more item is taken into the skid entry,
// then in_stall rises (it is a register, no combinational path from out_stall).
// Stalled results hold steady.
// Reset (rst_n low, synchronous): phase idle, duty 0, lifetime off, no pending
// command, configuration back to its defaults, both channels empty.
module solenoid_hit_hold_fade_driver_core #(
  parameter int TICKS_PER_SECOND = shhf_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  shhf_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output shhf_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [shhf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [shhf_pkg::CFG_W-1:0]        cfg_wdata
);

  shhf_pkg::cfg_t   cfg_r;
  shhf_pkg::state_t st_r, st_nxt;
  shhf_pkg::out_t   res;

  shhf_pkg::out_t   out_data_r, skid_data_r;
  logic             out_valid_r, skid_valid_r;

  logic in_xfer, out_xfer, main_free;

  assign in_stall  = skid_valid_r;
  assign in_xfer   = in_valid && !skid_valid_r;
  assign out_xfer  = out_valid_r && !out_stall;
  // main output slot can take new data this cycle
  assign main_free = out_xfer || !out_valid_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hit_duty     <= shhf_pkg::HIT_DUTY_RST;
      cfg_r.hold_duty    <= shhf_pkg::HOLD_DUTY_RST;
      cfg_r.hit_ms       <= shhf_pkg::HIT_MS_RST;
      cfg_r.fade_step_ms <= shhf_pkg::FADE_STEP_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        shhf_pkg::CFG_HIT_DUTY:     cfg_r.hit_duty     <= cfg_wdata[7:0];
        shhf_pkg::CFG_HOLD_DUTY:    cfg_r.hold_duty    <= cfg_wdata[7:0];
        shhf_pkg::CFG_HIT_MS:       cfg_r.hit_ms       <= cfg_wdata[15:0];
        shhf_pkg::CFG_FADE_STEP_MS: cfg_r.fade_step_ms <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // next-state logic for one item
  shhf_step #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (in_data),
    .st_nxt (st_nxt)
  );

  // driver state, advanced on every input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: shhf_pkg::PH_IDLE, default: '0};
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  assign res.duty         = st_nxt.duty;
  assign res.phase        = st_nxt.phase;
  assign res.life_running = st_nxt.lact;

  // result register with one skid entry; skid drains first to keep order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_xfer) begin
        out_data_r <= res;
      end
    end else if (in_xfer) begin
      skid_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/shhf_chk.sv]
module shhf_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input shhf_pkg::out_t out_data
);

  // a stalled result stays and holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // idle is reached only after the fade has run down to zero
  a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.phase == shhf_pkg::PH_IDLE |-> out_data.duty == 8'd0)
    else $error("idle result with nonzero duty");

  // lifetime countdown never runs while idle or fading
  a_life_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.phase == shhf_pkg::PH_IDLE ||
                  out_data.phase == shhf_pkg::PH_FADE) |-> !out_data.life_running)
    else $error("lifetime running outside hit or hold");

  // reset empties the result channel
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind solenoid_hit_hold_fade_driver_core shhf_chk u_shhf_chk (.*);

[tb/sv/solenoid_hit_hold_fade_driver_core_tb.sv]
module solenoid_hit_hold_fade_driver_core_tb;
  import shhf_pkg::*;

  // Mode code with no meaning to the driver; the item only echoes the state.
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int N_DIR = 28;

  typedef enum logic {ROW_ITEM, ROW_REGS} row_kind_t;

  // One line of the directed table: either a full register set, loaded once
  // the driver has drained, or one input transfer. Where typed is set, the
  // expected result is the one written in the row.
  typedef struct packed {
    row_kind_t kind;
    cfg_t      regs;
    in_t       item;
    logic      typed;
    out_t      want;
  } dir_row_t;

  localparam cfg_t NO_REGS = '0;
  localparam out_t NO_WANT = '0;

  localparam dir_row_t DIR_TAB [N_DIR] = '{
    // straight out of reset: idle, duty 0, no lifetime
    '{ROW_ITEM, NO_REGS, '{MODE_TICK, 16'h0000}, 1'b1, '{8'h00, PH_IDLE, 1'b0}},
    // fourth mode code is ignored
    '{ROW_ITEM, NO_REGS, '{MODE_NONE, 16'hFFFF}, 1'b1, '{8'h00, PH_IDLE, 1'b0}},
    // zero hit length, zero fade step (acts as one tick)
    '{ROW_REGS, '{8'hFF, 8'h01, 16'd0, 10'd0}, '0, 1'b0, NO_WANT},
    // off while idle: fade from duty 0 for one step
    '{ROW_ITEM, NO_REGS, '{MODE_OFF, 16'hFFFF}, 1'b1, '{8'h00, PH_FADE, 1'b0}},
    '{ROW_ITEM, NO_REGS, '{MODE_TICK, 16'h0000}, 1'b1, '{8'h00, PH_IDLE, 1'b0}},
    // on with no hit phase goes straight to hold
    '{ROW_ITEM, NO_REGS, '{MODE_ON, 16'h0000}, 1'b1, '{8'h01, PH_HOLD, 1'b1}},
    // zero lifetime expires on the next tick, fade timer not counted yet
    '{ROW_ITEM, NO_REGS, '{MODE_TICK, 16'h0000}, 1'b1, '{8'h01, PH_FADE, 1'b0}},
    '{ROW_ITEM, NO_REGS, '{MODE_TICK, 16'h0000}, 1'b1, '{8'h00, PH_FADE, 1'b0}},
    // on during fade waits; lifetime it loads is not counted on that tick
    '{ROW_ITEM, NO_REGS, '{MODE_ON, 16'hFFFF}, 1'b0, NO_WANT},
    '{ROW_ITEM, NO_REGS, '{MODE_TICK, 16'h0000}, 1'b0, NO_WANT},
    '{ROW_REGS, '{8'hA5, 8'h02, 16'd2, 10'd1}, '0, 1'b0, NO_WANT},
    // on while holding restarts the hit phase; off during hit waits
    '{ROW_ITEM, NO_REGS, '{MODE_ON, 16'h0001}, 1'b0, NO_WANT},
    '{ROW_ITEM, NO_REGS, '{MODE_OFF, 16'h0000}, 1'b0, NO_WANT},
    '{ROW_ITEM, NO_REGS, '{MODE_TICK, 16'h0000}, 1'b0, NO_WANT},
    '{ROW_ITEM, NO_REGS, '{MODE_TICK, 16'h0000}, 1'b0, NO_WANT},
    '{ROW_ITEM, NO_REGS, '{MODE_TICK, 16'h0000}, 1'b0, NO_WANT},
    '{ROW_ITEM, NO_REGS, '{MODE_TICK, 16'h0000}, 1'b0, NO_WANT},
    '{ROW_ITEM, NO_REGS, '{MODE_TICK, 16'h0000}, 1'b0, NO_WANT},
    '{ROW_REGS, '{8'h00, 8'h00, 16'd1, 10'd1}, '0, 1'b0, NO_WANT},
    // expiry during hit parks an off, taken when hit ends on the same tick
    '{ROW_ITEM, NO_REGS, '{MODE_ON, 16'h0000}, 1'b1, '{8'h00, PH_HIT, 1'b1}},
    '{ROW_ITEM, NO_REGS, '{MODE_TICK, 16'h0000}, 1'b1, '{8'h00, PH_FADE, 1'b0}},
    '{ROW_ITEM, NO_REGS, '{MODE_TICK, 16'h0000}, 1'b1, '{8'h00, PH_IDLE, 1'b0}},
    // newer on overwrites nothing yet, then off overwrites a fresh slot
    '{ROW_ITEM, NO_REGS, '{MODE_ON, 16'h5A5A}, 1'b0, NO_WANT},
    '{ROW_ITEM, NO_REGS, '{MODE_ON, 16'hA5A5}, 1'b0, NO_WANT},
    '{ROW_ITEM, NO_REGS, '{MODE_TICK, 16'h0000}, 1'b0, NO_WANT},
    '{ROW_ITEM, NO_REGS, '{MODE_OFF, 16'h0000}, 1'b0, NO_WANT},
    '{ROW_ITEM, NO_REGS, '{MODE_TICK, 16'h0000}, 1'b0, NO_WANT},
    '{ROW_ITEM, NO_REGS, '{MODE_TICK, 16'h0000}, 1'b0, NO_WANT}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // Driver state as the bench sees it.
  phase_t            m_phase;
  logic [7:0]        m_duty;
  logic [TMR_W-1:0]  m_tmr;
  logic [LIFE_W-1:0] m_life;
  logic              m_life_on;
  logic              m_pend;
  logic              m_pend_on;
  logic [SECS_W-1:0] m_pend_secs;

  // Register copies.
  logic [7:0]  r_hit_duty;
  logic [7:0]  r_hold_duty;
  logic [15:0] r_hit_ms;
  logic [9:0]  r_fade_step;

  out_t        drive_due [$];   // results still owed by the driver, oldest first
  int          mismatch_cnt = 0;
  int          results_seen = 0;
  int unsigned cycle_cnt = 0;
  logic        snd_gappy = 1'b0;
  logic        rcv_gappy = 1'b0;

  solenoid_hit_hold_fade_driver_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver prediction
  // ---------------------------------------------------------------------------

  // A zero fade step behaves as one tick.
  function automatic logic [TMR_W-1:0] fade_ticks();
    return (r_fade_step == '0) ? TMR_W'(1) : TMR_W'(r_fade_step);
  endfunction

  function automatic void take_cmd(logic turn_on, logic [SECS_W-1:0] secs);
    if (turn_on) begin
      m_life    = LIFE_W'(secs * TICKS_PER_SECOND_DEF);
      m_life_on = 1'b1;
      if (r_hit_ms == '0) begin
        m_phase = PH_HOLD;
        m_duty  = r_hold_duty;
      end else begin
        m_phase = PH_HIT;
        m_duty  = r_hit_duty;
        m_tmr   = r_hit_ms;
      end
    end else begin
      m_life_on = 1'b0;
      m_phase   = PH_FADE;
      m_tmr     = fade_ticks();
    end
  endfunction

  // Hit and fade can't be interrupted: the command parks in the single slot,
  // overwriting whatever was parked there.
  function automatic void route_cmd(logic turn_on, logic [SECS_W-1:0] secs);
    if (m_phase == PH_HIT || m_phase == PH_FADE) begin
      m_pend      = 1'b1;
      m_pend_on   = turn_on;
      m_pend_secs = secs;
    end else begin
      take_cmd(turn_on, secs);
    end
  endfunction

  function automatic void take_pending();
    if (m_pend) begin
      m_pend = 1'b0;
      take_cmd(m_pend_on, m_pend_secs);
    end
  endfunction

  // Advances the bench's copy of the driver by one item and returns the
  // duty, phase and lifetime flag it should then show.
  function automatic out_t drive_after(in_t it);
    phase_t was;
    logic   skip;
    out_t   res;
    skip = 1'b0;
    case (it.mode)
      MODE_TICK: begin
        // lifetime is counted first; an expiry that starts a fade ends the tick
        if (m_life_on) begin
          if (m_life != '0) m_life--;
          if (m_life == '0) begin
            was       = m_phase;
            m_life_on = 1'b0;
            route_cmd(1'b0, '0);
            skip = (m_phase != was);
          end
        end
        if (!skip) begin
          case (m_phase)
            PH_HIT: begin
              if (m_tmr != '0) m_tmr--;
              if (m_tmr == '0) begin
                m_phase = PH_HOLD;
                m_duty  = r_hold_duty;
                take_pending();
              end
            end
            PH_FADE: begin
              if (m_tmr != '0) m_tmr--;
              if (m_tmr == '0) begin
                if (m_duty != '0) begin
                  m_duty--;
                  m_tmr = fade_ticks();
                end else begin
                  m_phase = PH_IDLE;
                  take_pending();
                end
              end
            end
            default: ;
          endcase
        end
      end
      MODE_ON:  route_cmd(1'b1, it.life_seconds);
      MODE_OFF: route_cmd(1'b0, '0);
      default: ;
    endcase
    res.duty         = m_duty;
    res.phase        = m_phase;
    res.life_running = m_life_on;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------

  // Drops in_valid and waits until every owed result has come back. Every
  // item yields a result, so an empty queue means nothing is in flight.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk);
  endtask

  // Writes one register; cfg_we stays high so back-to-back writes need no gap.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_HIT_DUTY:     r_hit_duty  = data[7:0];
      CFG_HOLD_DUTY:    r_hold_duty = data[7:0];
      CFG_HIT_MS:       r_hit_ms    = data[15:0];
      CFG_FADE_STEP_MS: r_fade_step = data[9:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(cfg_t s);
    wait_drained();
    write_reg(CFG_HIT_DUTY, CFG_W'(s.hit_duty));
    write_reg(CFG_HOLD_DUTY, CFG_W'(s.hold_duty));
    write_reg(CFG_HIT_MS, CFG_W'(s.hit_ms));
    write_reg(CFG_FADE_STEP_MS, CFG_W'(s.fade_step_ms));
    cfg_we <= 1'b0;
  endtask

  // One input transfer. The idle gap comes first so that a back-to-back item
  // keeps in_valid high without a drop in the same step; the expectation is
  // queued at the accepting edge, before its result can show up.
  task automatic offer(in_t it, logic typed, out_t want);
    int   gap;
    out_t calc;
    gap = snd_gappy ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    calc = drive_after(it);
    drive_due.push_back(typed ? want : calc);
  endtask

  // Mostly ticks, so timers run out and parked commands get taken; on
  // commands favor a zero lifetime so expiry keeps happening.
  task automatic run_burst(cfg_t s, int n);
    in_t it;
    int  pick;
    load_settings(s);
    snd_gappy = 1'($urandom_range(0, 1));
    repeat (n) begin
      pick            = $urandom_range(0, 99);
      it.life_seconds = SECS_W'($urandom());
      if (pick < 72) begin
        it.mode = MODE_TICK;
      end else if (pick < 84) begin
        it.mode = MODE_ON;
        pick    = $urandom_range(0, 99);
        if (pick < 55) it.life_seconds = '0;
        else if (pick < 80) it.life_seconds = SECS_W'($urandom_range(1, 2));
      end else if (pick < 95) begin
        it.mode = MODE_OFF;
      end else begin
        it.mode = MODE_NONE;
      end
      offer(it, 1'b0, NO_WANT);
    end
  endtask

  initial begin
    cfg_t s;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    out_stall <= 1'b0;

    m_phase     = PH_IDLE;
    m_duty      = '0;
    m_tmr       = '0;
    m_life      = '0;
    m_life_on   = 1'b0;
    m_pend      = 1'b0;
    m_pend_on   = 1'b0;
    m_pend_secs = '0;
    r_hit_duty  = HIT_DUTY_RST;
    r_hold_duty = HOLD_DUTY_RST;
    r_hit_ms    = HIT_MS_RST;
    r_fade_step = FADE_STEP_MS_RST;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; items go back to back, with no idle gaps between them
    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_TAB[i].kind == ROW_REGS) load_settings(DIR_TAB[i].regs);
      else offer(DIR_TAB[i].item, DIR_TAB[i].typed, DIR_TAB[i].want);
    end

    // A one second lifetime run out by ticks alone: checks the load of the
    // countdown, the expiry in hold and the fade that follows.
    s = '{hit_duty: 8'($urandom_range(0, 255)), hold_duty: 8'($urandom_range(1, 8)),
          hit_ms: 16'($urandom_range(1, 6)), fade_step_ms: 10'($urandom_range(1, 2))};
    load_settings(s);
    offer('{MODE_ON, SECS_W'(1)}, 1'b0, NO_WANT);
    for (int k = 0; k < 1010; k++) begin
      if (k % 250 == 0) snd_gappy = 1'($urandom_range(0, 1));
      offer('{MODE_TICK, SECS_W'($urandom())}, 1'b0, NO_WANT);
    end

    // short timers so every phase and the parked slot keep turning over;
    // one burst with every register at its low end
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        s = '{hit_duty: 8'h00, hold_duty: 8'h00, hit_ms: 16'd0, fade_step_ms: 10'd0};
      end else begin
        s = '{hit_duty: 8'($urandom_range(0, 255)), hold_duty: 8'($urandom_range(0, 12)),
              hit_ms: 16'($urandom_range(0, 8)), fade_step_ms: 10'($urandom_range(0, 3))};
      end
      run_burst(s, 70);
    end

    // full duties: long fades with commands parked and overwritten
    run_burst('{hit_duty: 8'hFF, hold_duty: 8'hFF, hit_ms: 16'd0, fade_step_ms: 10'd0}, 180);
    // longest timers last, since the driver stays in hit or fade from here on
    run_burst('{hit_duty: 8'h00, hold_duty: 8'hFF, hit_ms: 16'hFFFF,
                fade_step_ms: 10'h3FF}, 40);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string what);
    $display("MISMATCH result %0d: %s", results_seen, what);
    mismatch_cnt++;
  endtask

  // Receiver: stalls a random number of cycles before each transfer, in
  // stretches with and without stalls. Twice it holds off for a long time
  // while the sender keeps going, so the skid entry fills and in_stall rises.
  initial begin
    out_t got;
    out_t want;
    int   hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_seen % 50 == 0) rcv_gappy = 1'($urandom_range(0, 1));
      hold = rcv_gappy ? $urandom_range(0, 8) : 0;
      if (results_seen == 150 || results_seen == 1200) hold = 60;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = out_data;
      results_seen++;
      if (drive_due.size() == 0) begin
        flag_mismatch("result with nothing outstanding");
      end else begin
        want = drive_due.pop_front();
        if (got.duty !== want.duty)
          flag_mismatch($sformatf("duty %0d, want %0d", got.duty, want.duty));
        if (got.phase !== want.phase)
          flag_mismatch($sformatf("phase %0d, want %0d", got.phase, want.phase));
        if (got.life_running !== want.life_running)
          flag_mismatch($sformatf("life_running %0b, want %0b",
                                  got.life_running, want.life_running));
      end
    end
  end

endmodule
